>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the IMU calibration RTL. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> design/imu_cal_pkg.sv
// ----------------------------------------------------------------------------
// imu_cal_pkg
// Widths, command codes, register indexes and control structs shared by the
// IMU bias calibration modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imu_cal_pkg;

   localparam int unsigned SAMPLE_W       = 16;
   localparam int unsigned SUM_W          = 32;
   localparam int unsigned COUNT_W        = 16;
   localparam int unsigned RANGE_W        = 2;
   localparam int unsigned CSR_IDX_W      = 2;
   localparam int unsigned MAX_AXES       = 3;
   localparam int unsigned MAX_LANES      = 2 * MAX_AXES;
   localparam int unsigned AXIS_COUNT_DEF = 3;
   localparam int unsigned DIV_STEPS      = SUM_W;

   localparam logic [SAMPLE_W-1:0] ONE_G_BASE = 16'd2048;

   localparam logic [CSR_IDX_W-1:0] REG_REQUIRED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE    = 2'd1;

   typedef enum logic [1:0] {
      CMD_CORRECT = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_START   = 2'd2,
      CMD_RSVD    = 2'd3
   } cmd_type;

   // lanes 0..2 accel x/y/z, lanes 3..5 gyro x/y/z
   typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] imu_vec_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic div_start;
      logic div_store;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic need_div;
      logic div_done;
      logic div_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> design/imu_bias_calibration.sv
// ----------------------------------------------------------------------------
// imu_bias_calibration
// Six-axis IMU bias removal with averaged-offset calibration.
// ----------------------------------------------------------------------------
// Each request carries three accel and three gyro samples and returns them
// minus the stored biases, using the biases held before that request's
// command. A plain request is held in the request register and, once the
// response side is free, its result is registered. Requests are taken one
// at a time, and the next request is taken even while an earlier result is
// still held on the response side. The request that completes a calibration
// also runs the averaging on one shared bit-serial divider, one lane after
// another for 2*AXIS_COUNT lanes, and the next request is accepted only
// after the last lane's bias is stored. The response itself does not wait
// for the divider. Configuration registers are always ready and take effect
// at the next start command (range code at the completing sample).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_bias_calibration #(
   parameter int unsigned AXIS_COUNT = imu_cal_pkg::AXIS_COUNT_DEF
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire         [1:0]                           req_cmd,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_accel_x_in,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_accel_y_in,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_accel_z_in,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_gyro_x_in,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_gyro_y_in,
   input  wire  signed [imu_cal_pkg::SAMPLE_W-1:0]     req_gyro_z_in,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_accel_x_out,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_accel_y_out,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_accel_z_out,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_gyro_x_out,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_gyro_y_out,
   output logic signed [imu_cal_pkg::SAMPLE_W-1:0]     rsp_gyro_z_out,
   output logic                                        rsp_status,
   output logic                                        rsp_calibration_done,
   input  wire                                         csr_valid,
   output logic                                        csr_ready,
   input  wire         [imu_cal_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire         [imu_cal_pkg::COUNT_W-1:0]      csr_data
);
   import imu_cal_pkg::*;

   localparam int unsigned SEL_W = $clog2(2 * AXIS_COUNT);

   ctrl_cmd_type          cmd;
   dp_stat_type           stat;
   logic [SEL_W-1:0]      div_sel;
   imu_vec_type           req_vec;
   imu_vec_type           rsp_vec;

   assign req_vec[0] = req_accel_x_in;
   assign req_vec[1] = req_accel_y_in;
   assign req_vec[2] = req_accel_z_in;
   assign req_vec[3] = req_gyro_x_in;
   assign req_vec[4] = req_gyro_y_in;
   assign req_vec[5] = req_gyro_z_in;

   imu_cal_ctrl #(
      .AXIS_COUNT (AXIS_COUNT),
      .SEL_W      (SEL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .div_sel   (div_sel)
   );

   imu_cal_dp #(
      .AXIS_COUNT (AXIS_COUNT),
      .SEL_W      (SEL_W)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .div_sel              (div_sel),
      .stat                 (stat),
      .req_cmd              (cmd_type'(req_cmd)),
      .req_vec              (req_vec),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_vec              (rsp_vec),
      .rsp_status           (rsp_status),
      .rsp_calibration_done (rsp_calibration_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   assign rsp_accel_x_out = rsp_vec[0];
   assign rsp_accel_y_out = rsp_vec[1];
   assign rsp_accel_z_out = rsp_vec[2];
   assign rsp_gyro_x_out  = rsp_vec[3];
   assign rsp_gyro_y_out  = rsp_vec[4];
   assign rsp_gyro_z_out  = rsp_vec[5];

endmodule

`default_nettype wire

>>> design/imu_cal_div.sv
// ----------------------------------------------------------------------------
// imu_cal_div
// Bit-serial signed-by-unsigned divider: one quotient bit per cycle,
// truncation toward zero, quotient wrapped to the sample width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imu_cal_div (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire  [imu_cal_pkg::SUM_W-1:0]        dividend,
   input  wire  [imu_cal_pkg::COUNT_W-1:0]      divisor,
   output logic                                 busy,
   output logic                                 done,
   output logic [imu_cal_pkg::SAMPLE_W-1:0]     quotient
);
   import imu_cal_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [SUM_W-1:0]      dvd_ff, dvd_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]    dsr_ff, dsr_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;

   logic [COUNT_W:0]      trial;
   logic [COUNT_W:0]      diff;
   logic                  fits;
   logic                  last;

   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};
   assign last  = cnt_ff == STEP_W'(DIV_STEPS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         dvd_in  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[SUM_W-2:0], fits};
         rem_in = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         cnt_in = cnt_ff + STEP_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (SAMPLE_W'(0) - dvd_ff[SAMPLE_W-1:0]) : dvd_ff[SAMPLE_W-1:0];

   `ASSERT_NEVER(a_done_while_busy, clock, reset, done_ff && busy_ff)

endmodule

`default_nettype wire

>>> design/imu_cal_dp.sv
// ----------------------------------------------------------------------------
// imu_cal_dp
// Datapath: request and result registers, configuration registers, running
// sums, bias store, bias correction and the shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imu_cal_dp #(
   parameter int unsigned AXIS_COUNT = imu_cal_pkg::AXIS_COUNT_DEF,
   parameter int unsigned SEL_W      = $clog2(2 * AXIS_COUNT)
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  imu_cal_pkg::ctrl_cmd_type            cmd,
   input  wire  [SEL_W-1:0]                     div_sel,
   output imu_cal_pkg::dp_stat_type             stat,
   input  imu_cal_pkg::cmd_type                 req_cmd,
   input  imu_cal_pkg::imu_vec_type             req_vec,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output imu_cal_pkg::imu_vec_type             rsp_vec,
   output logic                                 rsp_status,
   output logic                                 rsp_calibration_done,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [imu_cal_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [imu_cal_pkg::COUNT_W-1:0]      csr_data
);
   import imu_cal_pkg::*;

   localparam int unsigned LANES = 2 * AXIS_COUNT;
   localparam bit          HAS_Z = AXIS_COUNT > 2;
   localparam logic [SEL_W-1:0] Z_SEL = SEL_W'(MAX_AXES - 1);

   cmd_type               req_cmd_ff;
   imu_vec_type           req_vec_ff;

   logic [COUNT_W-1:0]    required_ff, required_in;
   logic [RANGE_W-1:0]    range_ff, range_in;

   logic [SUM_W-1:0]      sum_ff [LANES];
   logic [SUM_W-1:0]      sum_in [LANES];
   logic [SAMPLE_W-1:0]   bias_ff [LANES];
   logic [SAMPLE_W-1:0]   bias_in [LANES];
   logic [COUNT_W-1:0]    taken_ff, taken_in;
   logic [COUNT_W-1:0]    latched_ff, latched_in;
   logic                  armed_ff, armed_in;
   logic                  finished_ff, finished_in;
   logic [SAMPLE_W-1:0]   gee_ff, gee_in;

   imu_vec_type           out_vec_ff, out_vec_in;
   logic                  out_status_ff, out_status_in;
   logic                  out_done_ff, out_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   imu_vec_type           corr;
   logic [SAMPLE_W-1:0]   lane_sample [LANES];
   logic [COUNT_W-1:0]    taken_inc;
   logic                  start_ok;
   logic                  add_ok;
   logic                  complete;
   logic                  status_bit;

   logic                  div_busy;
   logic                  div_done;
   logic [SAMPLE_W-1:0]   div_quo;

   for (genvar k = 0; k < MAX_LANES; k++) begin : g_corr
      localparam int unsigned AX = k % MAX_AXES;
      localparam int unsigned GY = k / MAX_AXES;
      if (AX < AXIS_COUNT) begin : g_live
         localparam int unsigned IDX = GY * AXIS_COUNT + AX;
         assign corr[k] = req_vec_ff[k] - bias_ff[IDX];
      end else begin : g_dead
         assign corr[k] = req_vec_ff[k];
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      localparam int unsigned SRC = (j < AXIS_COUNT) ? j : MAX_AXES + j - AXIS_COUNT;
      assign lane_sample[j] = req_vec_ff[SRC];
   end

   assign taken_inc = taken_ff + COUNT_W'(1);
   assign start_ok  = required_ff != '0;
   assign add_ok    = armed_ff && !finished_ff && (latched_ff != '0);
   assign complete  = (req_cmd_ff == CMD_ADD) && add_ok && (taken_inc >= latched_ff);

   always_comb begin
      case (req_cmd_ff)
         CMD_CORRECT: status_bit = 1'b0;
         CMD_ADD:     status_bit = !add_ok;
         CMD_START:   status_bit = !start_ok;
         CMD_RSVD:    status_bit = 1'b1;
         default:     status_bit = 1'b1;
      endcase
   end

   imu_cal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff[div_sel]),
      .divisor  (latched_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      required_in   = required_ff;
      range_in      = range_ff;
      sum_in        = sum_ff;
      bias_in       = bias_ff;
      taken_in      = taken_ff;
      latched_in    = latched_ff;
      armed_in      = armed_ff;
      finished_in   = finished_ff;
      gee_in        = gee_ff;
      out_vec_in    = out_vec_ff;
      out_status_in = out_status_ff;
      out_done_in   = out_done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         case (csr_index)
            REG_REQUIRED: required_in = csr_data;
            REG_RANGE:    range_in    = csr_data[RANGE_W-1:0];
            default:      ;
         endcase
      end

      if (cmd.exec) begin
         if ((req_cmd_ff == CMD_START) && start_ok) begin
            for (int i = 0; i < LANES; i++) begin
               sum_in[i]  = '0;
               bias_in[i] = '0;
            end
            taken_in    = '0;
            latched_in  = required_ff;
            armed_in    = 1'b1;
            finished_in = 1'b0;
         end else if ((req_cmd_ff == CMD_ADD) && add_ok) begin
            for (int i = 0; i < LANES; i++) begin
               sum_in[i] = sum_ff[i]
                         + {{(SUM_W-SAMPLE_W){lane_sample[i][SAMPLE_W-1]}}, lane_sample[i]};
            end
            taken_in = taken_inc;
            if (complete) begin
               finished_in = 1'b1;
               gee_in      = ONE_G_BASE << range_ff;
            end
         end
         out_vec_in    = corr;
         out_status_in = status_bit;
         out_done_in   = finished_in;
         rsp_valid_in  = 1'b1;
      end

      if (cmd.div_store) begin
         bias_in[div_sel] = (HAS_Z && (div_sel == Z_SEL)) ? (div_quo - gee_ff) : div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff  <= '0;
         range_ff     <= '0;
         taken_ff     <= '0;
         latched_ff   <= '0;
         armed_ff     <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         required_ff  <= required_in;
         range_ff     <= range_in;
         taken_ff     <= taken_in;
         latched_ff   <= latched_in;
         armed_ff     <= armed_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         bias_ff      <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_cmd_ff <= req_cmd;
         req_vec_ff <= req_vec;
      end
      gee_ff        <= gee_in;
      out_vec_ff    <= out_vec_in;
      out_status_ff <= out_status_in;
      out_done_ff   <= out_done_in;
   end

   assign stat.out_free         = !rsp_valid_ff || !rsp_stall;
   assign stat.need_div         = complete;
   assign stat.div_done         = div_done;
   assign stat.div_busy         = div_busy;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_vec               = out_vec_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_calibration_done  = out_done_ff;
   assign csr_ready             = 1'b1;

   `ASSERT_NEVER(a_start_while_busy, clock, reset, cmd.div_start && div_busy)
   `ASSERT_NEXT(a_complete_marks_done, clock, reset, cmd.exec && complete, finished_ff)

endmodule

`default_nettype wire

>>> design/imu_cal_ctrl.sv
// ----------------------------------------------------------------------------
// imu_cal_ctrl
// Controller: takes one request at a time, issues the correction step and,
// on the completing calibration sample, walks the divider over every lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imu_cal_ctrl #(
   parameter int unsigned AXIS_COUNT = imu_cal_pkg::AXIS_COUNT_DEF,
   parameter int unsigned SEL_W      = $clog2(2 * AXIS_COUNT)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  imu_cal_pkg::dp_stat_type     stat,
   output imu_cal_pkg::ctrl_cmd_type    cmd,
   output logic [SEL_W-1:0]             div_sel
);
   import imu_cal_pkg::*;

   localparam int unsigned      LANES    = 2 * AXIS_COUNT;
   localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(LANES - 1);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_EXEC     = 4'b0010,
      ST_DIV_GO   = 4'b0100,
      ST_DIV_WAIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               sel_in   = '0;
               state_in = stat.need_div ? ST_DIV_GO : ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               if (sel_ff == SEL_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in   = sel_ff + SEL_W'(1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign div_sel = sel_ff;

   `ASSERT_NEXT(a_plain_item_idle, clock, reset, cmd.exec && !stat.need_div, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_divider_started, clock, reset, state_ff == ST_DIV_GO, stat.div_busy)
   `ASSERT_NEVER(a_sel_range, clock, reset, sel_ff > SEL_LAST)

endmodule

`default_nettype wire
